// File: rtl/core/aeg_pkg.sv
package aeg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 17;
    localparam int ENV_W      = 32;
    localparam int DIFF_W     = ENV_W + 1;
    localparam int ACC_W      = ENV_W + 2;
    localparam int COEF_W     = 24;
    localparam int TARGET_W   = 15;
    localparam int GAIN_W     = 21;
    localparam int QUO_W      = 31;
    localparam int REM_W      = ENV_W + 1;
    localparam int PROD_W     = MAG_W + GAIN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int ENV_STEPS = COEF_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int MUL_STEPS = GAIN_W;
    localparam int CNT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_AGC_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CEILING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEF = 3'd4;

    localparam logic                RST_AGC_ENABLE   = 1'b1;
    localparam logic [TARGET_W-1:0] RST_TARGET_LEVEL = 15'd4000;
    localparam logic [GAIN_W-1:0]   RST_GAIN_CEILING = 21'd1310720;
    localparam logic [COEF_W-1:0]   RST_ATTACK_COEF  = 24'd16362984;
    localparam logic [COEF_W-1:0]   RST_RELEASE_COEF = 24'd16770227;

    localparam logic [ENV_W-1:0]    Q16_ONE      = 32'd65536;
    localparam logic [GAIN_W-1:0]   GAIN_UNITY   = 21'd65536;
    localparam logic [SAMPLE_W-1:0] POS_LIMIT    = 16'd32767;
    localparam logic [SAMPLE_W-1:0] NEG_LIMIT    = 16'd32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_GAIN,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } aeg_state_t;

    typedef struct packed {
        logic                start;
        logic [TARGET_W-1:0] num;
        logic [ENV_W-1:0]    den;
    } aeg_div_req_t;

endpackage

// File: rtl/core/aeg_div.sv
// quotient = (num << 32) / den, den > 2^16, one quotient bit per cycle
module aeg_div
    import aeg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  aeg_div_req_t       req,
    output logic               done,
    output logic [QUO_W-1:0]   quo
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ENV_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] rem_diff;
    logic             rem_ge;

    assign rem_sh   = {rem_reg[REM_W-2:0], 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // upper dividend bits never produce a quotient bit since num << 1 < den
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= REM_W'({req.num, 1'b0});
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_ge ? rem_diff : rem_sh;
            quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/core/audio_agc_envelope_gain.sv
// Audio AGC with attack/release envelope.
// Input channel: src_valid / src_stall with sample_in. A transaction takes
// place on a rising edge with src_valid high and src_stall low.
// Output channel: dst_valid / dst_stall with sample_out and gain_applied,
// held in an output register; the block takes the next sample while a
// finished result still waits there.
// Configuration: cfg_wr_en/cfg_index/cfg_data; write while idle, unenforced.
// With AGC enabled an item passes through the bit-serial envelope multiply,
// the bit-serial divider and the bit-serial gain multiply; when the
// envelope is at or below 1.0 the divider is skipped. With AGC disabled
// the sample passes through unchanged. src_stall is high from acceptance
// until the result moves to the output register.
// If dst_stall holds a result, the next one waits in its last step.
// Reset clears the envelope and loads the default register values.
module audio_agc_envelope_gain
    import aeg_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        src_valid,
    output logic                        src_stall,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    output logic                        dst_valid,
    input  logic                        dst_stall,
    output logic signed [SAMPLE_W-1:0]  sample_out,
    output logic        [GAIN_W-1:0]    gain_applied,
    input  logic                        cfg_wr_en,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data
);

    aeg_state_t state_reg, state_next;

    logic                agc_enable_reg;
    logic [TARGET_W-1:0] target_level_reg;
    logic [GAIN_W-1:0]   gain_ceiling_reg;
    logic [COEF_W-1:0]   attack_coef_reg;
    logic [COEF_W-1:0]   release_coef_reg;
    logic [ENV_W-1:0]    env_reg, env_next;
    logic                dst_valid_reg, dst_valid_next;

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [COEF_W-1:0]   csh_reg, csh_next;
    logic [DIFF_W-1:0]   diff_reg, diff_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [GAIN_W-1:0]   gsh_reg, gsh_next;
    logic [PROD_W-1:0]   pacc_reg, pacc_next;
    logic [SAMPLE_W-1:0] res_reg, res_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic [GAIN_W-1:0]   out_gain_reg, out_gain_next;

    logic                src_fire;
    logic [MAG_W-1:0]    in_mag;
    logic [ENV_W-1:0]    in_amag;
    logic [ENV_W-1:0]    cur_amag;
    logic [ACC_W-1:0]    acc_add;
    logic [ACC_W-1:0]    acc_sum;
    logic [ACC_W-1:0]    acc_shr;
    logic [ACC_W-1:0]    env_sum;
    logic [QUO_W-1:0]    gain_src;
    logic [GAIN_W-1:0]   gain_cap;
    logic [PROD_W-1:0]   pacc_step;
    logic [PROD_W-17:0]  prod;
    logic [SAMPLE_W-1:0] sat_mag;
    logic                out_free;

    aeg_div_req_t        div_req;
    logic                div_done;
    logic [QUO_W-1:0]    div_quo;

    aeg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign src_stall = (state_reg != ST_IDLE);
    assign src_fire  = src_valid && !src_stall;
    assign out_free  = !dst_valid_reg || !dst_stall;

    assign in_mag   = sample_in[SAMPLE_W-1] ? (MAG_W'(17'h10000) - {1'b0, sample_in})
                                            : {1'b0, sample_in};
    assign in_amag  = {in_mag[SAMPLE_W-1:0], 16'h0};
    assign cur_amag = {mag_reg[SAMPLE_W-1:0], 16'h0};

    // env' = A + floor(c * (env - A) / 2^24), c one bit per cycle, LSB first
    assign acc_add = csh_reg[0] ? {diff_reg[DIFF_W-1], diff_reg} : '0;
    assign acc_sum = acc_reg + acc_add;
    assign acc_shr = {acc_sum[ACC_W-1], acc_sum[ACC_W-1:1]};
    assign env_sum = {2'b00, cur_amag} + acc_shr;

    assign gain_src = (state_reg == ST_DIV) ? div_quo : QUO_W'(Q16_ONE);
    assign gain_cap = (gain_src > QUO_W'(gain_ceiling_reg)) ? gain_ceiling_reg
                                                             : gain_src[GAIN_W-1:0];

    // gain multiply, MSB first
    assign pacc_step = {pacc_reg[PROD_W-2:0], 1'b0}
                     + (gsh_reg[GAIN_W-1] ? PROD_W'(mag_reg) : '0);
    assign prod      = pacc_step[PROD_W-1:16];

    always_comb
    begin
        if (neg_reg)
            sat_mag = (prod > (PROD_W-16)'(NEG_LIMIT)) ? NEG_LIMIT : prod[SAMPLE_W-1:0];
        else
            sat_mag = (prod > (PROD_W-16)'(POS_LIMIT)) ? POS_LIMIT : prod[SAMPLE_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        env_next        = env_reg;
        dst_valid_next  = dst_valid_reg;
        cnt_next        = cnt_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        csh_next        = csh_reg;
        diff_next       = diff_reg;
        acc_next        = acc_reg;
        gain_next       = gain_reg;
        gsh_next        = gsh_reg;
        pacc_next       = pacc_reg;
        res_next        = res_reg;
        out_sample_next = out_sample_reg;
        out_gain_next   = out_gain_reg;
        div_req.start   = 1'b0;
        div_req.num     = target_level_reg;
        div_req.den     = env_reg;

        if (dst_valid_reg && !dst_stall)
            dst_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (src_fire)
                begin
                    neg_next  = sample_in[SAMPLE_W-1];
                    mag_next  = in_mag;
                    cnt_next  = '0;
                    acc_next  = '0;
                    diff_next = {1'b0, env_reg} - {1'b0, in_amag};
                    csh_next  = (in_amag > env_reg) ? attack_coef_reg : release_coef_reg;
                    res_next  = sample_in;
                    gain_next = GAIN_UNITY;
                    state_next = agc_enable_reg ? ST_ENV : ST_DONE;
                end
            end
            ST_ENV:
            begin
                acc_next = acc_shr;
                csh_next = {1'b0, csh_reg[COEF_W-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ENV_STEPS - 1))
                begin
                    env_next   = env_sum[ENV_W-1:0];
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                if (env_reg > Q16_ONE)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    gain_next  = gain_cap;
                    gsh_next   = gain_cap;
                    pacc_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    gain_next  = gain_cap;
                    gsh_next   = gain_cap;
                    pacc_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                pacc_next = pacc_step;
                gsh_next  = {gsh_reg[GAIN_W-2:0], 1'b0};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    res_next   = neg_reg ? (16'h0 - sat_mag) : sat_mag;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_sample_next = res_reg;
                    out_gain_next   = gain_reg;
                    dst_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg    <= 1'b0;
            env_reg          <= '0;
            agc_enable_reg   <= RST_AGC_ENABLE;
            target_level_reg <= RST_TARGET_LEVEL;
            gain_ceiling_reg <= RST_GAIN_CEILING;
            attack_coef_reg  <= RST_ATTACK_COEF;
            release_coef_reg <= RST_RELEASE_COEF;
            cnt_reg          <= '0;
        end
        else
        begin
            dst_valid_reg <= dst_valid_next;
            env_reg       <= env_next;
            cnt_reg       <= cnt_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_AGC_ENABLE:   agc_enable_reg   <= cfg_data[0];
                    CFG_TARGET_LEVEL: target_level_reg <= cfg_data[TARGET_W-1:0];
                    CFG_GAIN_CEILING: gain_ceiling_reg <= cfg_data[GAIN_W-1:0];
                    CFG_ATTACK_COEF:  attack_coef_reg  <= cfg_data[COEF_W-1:0];
                    CFG_RELEASE_COEF: release_coef_reg <= cfg_data[COEF_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        csh_reg        <= csh_next;
        diff_reg       <= diff_next;
        acc_reg        <= acc_next;
        gain_reg       <= gain_next;
        gsh_reg        <= gsh_next;
        pacc_reg       <= pacc_next;
        res_reg        <= res_next;
        out_sample_reg <= out_sample_next;
        out_gain_reg   <= out_gain_next;
    end

    assign dst_valid    = dst_valid_reg;
    assign sample_out   = out_sample_reg;
    assign gain_applied = out_gain_reg;

endmodule
